[sv/sbsa_pkg.sv]
`default_nettype none
package sbsa_pkg;

    // bitmap store geometry
    localparam int SLOT_STORE   = 512;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;
    localparam int NUM_WORDS    = 16;
    localparam int WORD_AW      = 4;
    localparam int SLOT_W       = 9;
    localparam int HINT_W       = 10;

    // field widths
    localparam int LG_W         = 4;
    localparam int REQ_W        = 15;
    localparam int OFF_W        = 14;
    localparam int BYTES_W      = 15;
    localparam int SLOT_BYTES_W = 16;

    localparam logic [LG_W-1:0]    CFG_RESET = 4'd5;
    localparam logic [BYTES_W-1:0] BYTES_MAX = 15'h7fff;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] byte_offset;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot_index;
        logic [BYTES_W-1:0] bytes_in_use;
        logic               has_room;
    } out_item_t;

    typedef struct packed {
        logic                 rd_en;
        logic [WORD_AW-1:0]   rd_addr;
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 clear;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FREE_CHK,
        ST_RESULT
    } state_t;

endpackage
`default_nettype wire

[sv/sbsa_bitmap_mem.sv]
`default_nettype none
module sbsa_bitmap_mem
    import sbsa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mem_req_t             req,
    output logic [WORD_BITS-1:0]      rdata
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] row_valid_reg;
    logic [NUM_WORDS-1:0] row_valid_next;
    logic [WORD_BITS-1:0] rd_raw_reg;
    logic                 rd_valid_reg;

    // rows never written since the last clear read as all free
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (req.clear)
        begin
            row_valid_next = '0;
        end
        else if (req.wr_en)
        begin
            row_valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rd_valid_reg ? rd_raw_reg : '0;

endmodule
`default_nettype wire

[sv/sbsa_find_free.sv]
`default_nettype none
module sbsa_find_free
    import sbsa_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [WORD_AW-1:0]   word_addr,
    input  wire logic [HINT_W-1:0]    hint,
    input  wire logic [HINT_W-1:0]    limit,
    output logic                      found,
    output logic [BIT_W-1:0]          bit_pos
);

    logic [WORD_BITS-1:0] cand;
    logic [HINT_W-1:0]    lane_idx;

    // a lane is a candidate if free and inside [hint, limit)
    always_comb
    begin
        cand     = '0;
        lane_idx = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            lane_idx = {1'b0, word_addr, BIT_W'(b)};
            cand[b]  = !word[b] && (lane_idx >= hint) && (lane_idx < limit);
        end
    end

    // lowest candidate wins
    always_comb
    begin
        bit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                bit_pos = BIT_W'(b);
            end
        end
    end

    assign found = |cand;

endmodule
`default_nettype wire

[sv/superblock_slot_allocator_top.sv]
`default_nettype none
// superblock slot allocator
//
// request channel (req_valid / req_stall / req_item) carries allocate or free
// commands; response channel (rsp_valid / rsp_stall / rsp_item) returns one
// result per request, in order. a transfer happens when valid is high and
// stall is low. cfg_valid / cfg_ready writes the slot size log2; a write
// re-cuts the superblock and clears the bitmap, hint and byte count at once.
//
// one request is in flight at a time. a refused request goes from decode
// straight to the result state, a free passes through the free check, and
// an allocate reads 32-bit bitmap words from the hint word upward (1 to 16
// words) in the scan state; the single-port bitmap read, one word per cycle,
// paces the scan. the next request is taken the cycle after the result
// lands in the output register, so a stalled result holds one item there
// while the next item is accepted and worked on.
//
// reset clears the bitmap through per-word valid flags (no sweep), the hint,
// the byte count, and loads slot size log2 = 5.
module superblock_slot_allocator_top
    import sbsa_pkg::*;
#(
    parameter int SUPERBLOCK_BYTES = 16384,
    parameter int MIN_SLOT_BYTES   = 32
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire in_item_t        req_item,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output out_item_t            rsp_item,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [LG_W-1:0] cfg_data
);

    // clamp range for the slot size log2
    localparam int LG_LO     = $clog2(MIN_SLOT_BYTES);
    localparam int LG_HI_RAW = $clog2(SUPERBLOCK_BYTES + 1) - 2;
    localparam int LG_HI     = (LG_HI_RAW < LG_LO) ? LG_LO : LG_HI_RAW;
    // byte counter wide enough for a full superblock
    localparam int UB_W      = $clog2(SUPERBLOCK_BYTES + 1);

    state_t               state_reg, state_next;
    in_item_t             item_reg;
    logic [LG_W-1:0]      lg_cfg_reg;
    logic [WORD_AW-1:0]   word_reg, word_next;
    logic [HINT_W-1:0]    hint_reg, hint_next;
    logic [UB_W-1:0]      used_reg, used_next;
    logic                 res_ok_reg, res_ok_next;
    logic [SLOT_W-1:0]    res_idx_reg, res_idx_next;
    logic                 rsp_valid_reg;
    out_item_t            rsp_item_reg;

    logic                 item_xfer;
    logic                 cfg_xfer;
    logic                 rsp_xfer;
    logic                 out_free;

    logic [LG_W-1:0]      lg_eff;
    logic [31:0]          n_full;
    logic [HINT_W-1:0]    n_slots;
    logic [31:0]          cap_full;
    logic [UB_W-1:0]      cap_bytes;
    logic [SLOT_BYTES_W-1:0] slot_bytes;
    logic [OFF_W-1:0]     free_idx;
    logic                 free_in_range;
    logic                 req_fits;
    logic                 hint_ok;
    logic [HINT_W-1:0]    next_word_base;
    logic                 scan_last;

    mem_req_t             mem_req;
    logic [WORD_BITS-1:0] rdata;
    logic                 ff_found;
    logic [BIT_W-1:0]     ff_bit;
    logic [HINT_W-1:0]    found_idx;
    logic                 free_bit_used;

    assign item_xfer = req_valid && !req_stall;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign rsp_xfer  = rsp_valid_reg && !rsp_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // effective geometry from the config register
    always_comb
    begin
        if (lg_cfg_reg < LG_W'(LG_LO))
        begin
            lg_eff = LG_W'(LG_LO);
        end
        else if (lg_cfg_reg > LG_W'(LG_HI))
        begin
            lg_eff = LG_W'(LG_HI);
        end
        else
        begin
            lg_eff = lg_cfg_reg;
        end
    end

    assign n_full     = 32'(SUPERBLOCK_BYTES) >> lg_eff;
    assign n_slots    = (n_full > 32'(SLOT_STORE)) ? HINT_W'(SLOT_STORE) : HINT_W'(n_full);
    assign cap_full   = 32'(n_slots) << lg_eff;
    assign cap_bytes  = UB_W'(cap_full);
    assign slot_bytes = SLOT_BYTES_W'(1) << lg_eff;

    // request decode against the held item
    assign free_idx      = item_reg.byte_offset >> lg_eff;
    assign free_in_range = free_idx < OFF_W'(n_slots);
    assign req_fits      = {1'b0, item_reg.request_bytes} <= slot_bytes;
    assign hint_ok       = hint_reg < n_slots;

    // base slot of the word after the one being scanned
    assign next_word_base = {({1'b0, word_reg} + 5'd1), {BIT_W{1'b0}}};
    assign scan_last      = next_word_base >= n_slots;

    assign found_idx     = {1'b0, word_reg, ff_bit};
    assign free_bit_used = rdata[free_idx[BIT_W-1:0]];

    sbsa_find_free u_find_free
    (
        .word      (rdata),
        .word_addr (word_reg),
        .hint      (hint_reg),
        .limit     (n_slots),
        .found     (ff_found),
        .bit_pos   (ff_bit)
    );

    sbsa_bitmap_mem u_bitmap_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (item_reg.mode == MODE_ALLOC)
                begin
                    state_next = (req_fits && hint_ok) ? ST_SCAN : ST_RESULT;
                end
                else
                begin
                    state_next = free_in_range ? ST_FREE_CHK : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (ff_found || scan_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_FREE_CHK:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: handshakes and bitmap port
    always_comb
    begin
        req_stall       = 1'b1;
        cfg_ready       = 1'b0;
        mem_req         = '0;
        mem_req.clear   = cfg_xfer;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cfg_ready = 1'b1;
            end
            ST_DECODE:
            begin
                if (item_reg.mode == MODE_ALLOC)
                begin
                    mem_req.rd_en   = req_fits && hint_ok;
                    mem_req.rd_addr = hint_reg[SLOT_W-1:BIT_W];
                end
                else
                begin
                    mem_req.rd_en   = free_in_range;
                    mem_req.rd_addr = free_idx[SLOT_W-1:BIT_W];
                end
            end
            ST_SCAN:
            begin
                if (ff_found)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = word_reg;
                    mem_req.wr_data = rdata | (WORD_BITS'(1) << ff_bit);
                end
                else if (!scan_last)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = word_reg + WORD_AW'(1);
                end
            end
            ST_FREE_CHK:
            begin
                if (free_bit_used)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = free_idx[SLOT_W-1:BIT_W];
                    mem_req.wr_data = rdata & ~(WORD_BITS'(1) << free_idx[BIT_W-1:0]);
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        word_next    = word_reg;
        hint_next    = hint_reg;
        used_next    = used_reg;
        res_ok_next  = res_ok_reg;
        res_idx_next = res_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_xfer)
                begin
                    hint_next = '0;
                    used_next = '0;
                end
            end
            ST_DECODE:
            begin
                res_ok_next  = 1'b0;
                res_idx_next = '0;
                word_next    = hint_reg[SLOT_W-1:BIT_W];
            end
            ST_SCAN:
            begin
                if (ff_found)
                begin
                    hint_next    = found_idx + HINT_W'(1);
                    used_next    = used_reg + UB_W'(slot_bytes);
                    res_ok_next  = 1'b1;
                    res_idx_next = found_idx[SLOT_W-1:0];
                end
                else if (!scan_last)
                begin
                    word_next = word_reg + WORD_AW'(1);
                end
            end
            ST_FREE_CHK:
            begin
                if (free_bit_used)
                begin
                    used_next    = used_reg - UB_W'(slot_bytes);
                    res_ok_next  = 1'b1;
                    res_idx_next = free_idx[SLOT_W-1:0];
                    if (HINT_W'(free_idx) < hint_reg)
                    begin
                        hint_next = HINT_W'(free_idx);
                    end
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lg_cfg_reg    <= CFG_RESET;
            hint_reg      <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            used_reg  <= used_next;
            if (cfg_xfer)
            begin
                lg_cfg_reg <= cfg_data;
            end
            if (state_reg == ST_RESULT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_xfer)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        res_ok_reg  <= res_ok_next;
        res_idx_reg <= res_idx_next;
        if (item_xfer)
        begin
            item_reg <= req_item;
        end
        if (state_reg == ST_RESULT && out_free)
        begin
            rsp_item_reg.ok         <= res_ok_reg;
            rsp_item_reg.slot_index <= res_idx_reg;
            rsp_item_reg.bytes_in_use <= (32'(used_reg) > 32'(BYTES_MAX)) ?
                                         BYTES_MAX : BYTES_W'(used_reg);
            rsp_item_reg.has_room   <= used_reg < cap_bytes;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // a refused or ignored request reports slot zero
    a_fail_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.ok || rsp_item.slot_index == '0))
        else $error("failed result carries a nonzero slot index");

    // bitmap port never reads and writes in the same cycle
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("bitmap read and write overlap");

    // bitmap writes only come from the scan or free check
    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == ST_SCAN || state_reg == ST_FREE_CHK))
        else $error("bitmap write outside scan or free check");

    // byte count never exceeds the superblock capacity
    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= cap_bytes)
        else $error("bytes in use beyond capacity");

    // hint stays within the slot store
    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= HINT_W'(SLOT_STORE))
        else $error("hint beyond slot store");

endmodule
`default_nettype wire

[tb/superblock_slot_allocator_top_test.sv]
module superblock_slot_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbsa_pkg::*;

    // geometry of the superblock as instantiated
    localparam int SB_BYTES   = 16384;
    localparam int MIN_LG     = 5;      // log2 of the 32-byte minimum slot
    localparam int MAX_LG     = 13;     // half the superblock
    localparam int LIMIT      = 500000; // run-away guard in clock cycles
    localparam int HOLD_LEN   = 300;    // long receiver hold-off in cycles
    localparam int QUIET_LO   = 600;    // transfers in [QUIET_LO, QUIET_HI) never idle
    localparam int QUIET_HI   = 850;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    in_item_t           req_item;
    logic               rsp_valid;
    logic               rsp_stall;
    out_item_t          rsp_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LG_W-1:0]    cfg_data;

    // allocator shadow state
    bit                 slot_busy [SLOT_STORE];
    int                 scan_hint;
    int                 held_bytes;
    logic [LG_W-1:0]    slot_lg_reg;

    in_item_t           requests_queued[$];   // items waiting for the driver
    out_item_t          slot_results_due[$];  // predicted results, oldest first
    out_item_t          result_due;

    int                 items_taken;
    int                 results_seen;
    int                 hold_left;
    int                 mismatches = 0;
    int                 cycles = 0;

    superblock_slot_allocator_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // register value clamped to the legal slot sizes
    function automatic int eff_lg();
        int lg;
        lg = int'(slot_lg_reg);
        if (lg < MIN_LG)
            lg = MIN_LG;
        if (lg > MAX_LG)
            lg = MAX_LG;
        return lg;
    endfunction

    function automatic int slot_total(input int lg);
        int n;
        n = SB_BYTES >> lg;
        return (n > SLOT_STORE) ? SLOT_STORE : n;
    endfunction

    // re-cutting the superblock drops every allocation
    function automatic void clear_shadow();
        foreach (slot_busy[i])
            slot_busy[i] = 1'b0;
        scan_hint  = 0;
        held_bytes = 0;
    endfunction

    // append one item to the driver queue
    function automatic void queue_item(input in_item_t it);
        requests_queued = {requests_queued, it};
    endfunction

    // one allocate or free against the shadow bitmap
    function automatic out_item_t allocator_predict(input in_item_t it);
        int        lg;
        int        slot;
        int        n;
        int        idx;
        out_item_t r;
        lg   = eff_lg();
        slot = 1 << lg;
        n    = slot_total(lg);
        r    = '0;
        if (it.mode == MODE_ALLOC)
        begin
            // oversized asks and a full tail above the hint are both refused
            if (int'(it.request_bytes) <= slot)
            begin
                for (idx = scan_hint; idx < n && !r.ok; idx++)
                begin
                    if (!slot_busy[idx])
                    begin
                        slot_busy[idx] = 1'b1;
                        held_bytes    += slot;
                        scan_hint      = idx + 1;
                        r.ok           = 1'b1;
                        r.slot_index   = SLOT_W'(idx);
                    end
                end
            end
        end
        else
        begin
            // freeing a slot that is not held is ignored, count untouched
            idx = int'(it.byte_offset) >> lg;
            if (idx < n && slot_busy[idx])
            begin
                slot_busy[idx] = 1'b0;
                held_bytes    -= slot;
                if (idx < scan_hint)
                    scan_hint = idx;
                r.ok         = 1'b1;
                r.slot_index = SLOT_W'(idx);
            end
        end
        r.bytes_in_use = (held_bytes > int'(BYTES_MAX)) ? BYTES_MAX : BYTES_W'(held_bytes);
        r.has_room     = (held_bytes < n * slot);
        return r;
    endfunction

    function automatic in_item_t mk(input logic m, input int req, input int off);
        in_item_t it;
        it.mode          = m;
        it.request_bytes = REQ_W'(req);
        it.byte_offset   = OFF_W'(off);
        return it;
    endfunction

    // random slot that the shadow currently holds
    function automatic bit pick_busy(input int lg, output int idx);
        int n;
        int start;
        n     = slot_total(lg);
        start = $urandom_range(n - 1);
        for (int k = 0; k < n; k++)
        begin
            if (slot_busy[(start + k) % n])
            begin
                idx = (start + k) % n;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // mostly well-formed traffic: fitting allocates and frees of held slots,
    // with oversized asks and stray frees mixed in; unused fields are noise
    function automatic in_item_t make_item(input int alloc_pct);
        in_item_t it;
        int       lg;
        int       idx;
        lg               = eff_lg();
        it.request_bytes = REQ_W'($urandom_range(SB_BYTES));
        it.byte_offset   = OFF_W'($urandom);
        if ($urandom_range(99) < alloc_pct)
        begin
            it.mode = MODE_ALLOC;
            if ($urandom_range(99) < 85)
                it.request_bytes = REQ_W'($urandom_range(1 << lg));
        end
        else
        begin
            it.mode = MODE_FREE;
            // any byte inside a held slot maps to that slot
            if ($urandom_range(99) < 80 && pick_busy(lg, idx))
                it.byte_offset = OFF_W'((idx << lg) | ($urandom & ((1 << lg) - 1)));
        end
        return it;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // every driven item accepted and every predicted result returned;
    // checked mid-cycle so the clocked processes have settled
    task automatic wait_drained();
        while (requests_queued.size() != 0 || req_valid || slot_results_due.size() != 0)
            @(negedge clk);
    endtask

    // config writes only while the allocator is idle; each one re-cuts the superblock
    task automatic write_slot_lg(input logic [LG_W-1:0] v);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        slot_lg_reg  = v;
        clear_shadow();
    endtask

    // feed random items, keeping the driver queue short so frees track live slots
    task automatic run_phase(input int count, input int alloc_pct);
        for (int k = 0; k < count; k++)
        begin
            while (requests_queued.size() > 1)
                @(posedge clk);
            queue_item(make_item(alloc_pct));
        end
    endtask

    // request driver: prediction is made at the transfer edge, in transfer order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            req_item    <= '0;
            items_taken <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                slot_results_due = {slot_results_due, allocator_predict(req_item)};
                items_taken <= items_taken + 1;
            end
            // payload may only move once the current one is taken
            if (!req_valid || !req_stall)
            begin
                if (requests_queued.size() != 0 &&
                    ((items_taken >= QUIET_LO && items_taken < QUIET_HI) ||
                     $urandom_range(99) >= 29))
                begin
                    req_item  <= requests_queued.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall    <= 1'b0;
            hold_left    <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (slot_results_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    result_due = slot_results_due.pop_front();
                    compare_field("ok", result_due.ok, rsp_item.ok);
                    compare_field("slot_index", result_due.slot_index, rsp_item.slot_index);
                    compare_field("bytes_in_use", result_due.bytes_in_use,
                                  rsp_item.bytes_in_use);
                    compare_field("has_room", result_due.has_room, rsp_item.has_room);
                end
                results_seen <= results_seen + 1;
            end
            // two long hold-offs so the allocator backs up into req_stall
            if (rsp_valid && !rsp_stall && (results_seen == 200 || results_seen == 1000))
            begin
                hold_left <= HOLD_LEN;
                rsp_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < 29);
            end
        end
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        slot_lg_reg = CFG_RESET;
        clear_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset slot size, 32-byte slots
        queue_item(mk(MODE_ALLOC, 0, 16383));     // smallest ask, slot 0
        queue_item(mk(MODE_ALLOC, 32, 0));        // exactly one slot
        queue_item(mk(MODE_ALLOC, 33, 0));        // one byte too many
        queue_item(mk(MODE_ALLOC, SB_BYTES, 0));  // largest ask
        queue_item(mk(MODE_FREE, SB_BYTES, 0));   // free slot 0, hint drops
        queue_item(mk(MODE_FREE, 0, 0));          // double free
        queue_item(mk(MODE_FREE, 0, 63));         // last byte of slot 1
        queue_item(mk(MODE_FREE, 0, 16383));      // top slot, never held
        queue_item(mk(MODE_ALLOC, 31, 0));        // reuses slot 0

        // largest slots: two of them, so the superblock fills at once
        write_slot_lg(4'd13);
        queue_item(mk(MODE_ALLOC, 8192, 0));
        queue_item(mk(MODE_ALLOC, 1, 0));         // full, has_room low
        queue_item(mk(MODE_ALLOC, 0, 0));         // refused when full
        queue_item(mk(MODE_FREE, 0, 16383));
        queue_item(mk(MODE_FREE, 0, 8192));       // double free
        queue_item(mk(MODE_ALLOC, 8193, 0));      // oversized
        queue_item(mk(MODE_FREE, 0, 0));
        queue_item(mk(MODE_ALLOC, 8192, 0));      // hint back at slot 0

        // random phases over several slot sizes, out-of-range codes clamp
        write_slot_lg(4'd8);
        run_phase(300, 65);
        write_slot_lg(4'd0);
        run_phase(400, 80);
        write_slot_lg(4'd15);
        run_phase(100, 55);
        write_slot_lg(4'd11);
        run_phase(200, 50);
        write_slot_lg(4'd6);
        run_phase(350, 75);
        write_slot_lg(4'd13);
        run_phase(150, 55);
        write_slot_lg(4'd5);
        run_phase(200, 60);

        wait_drained();
        repeat (24) @(posedge clk);
        if (mismatches == 0 && slot_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
